>>> rtl/gnz_pkg.sv
package gnz_pkg;

	localparam int COORD_FRAC_BITS = 16;
	localparam int OUT_FRAC_BITS   = 15;

	localparam int FW  = COORD_FRAC_BITS;
	localparam int UW  = FW + 1;
	localparam int OW  = FW + 2;
	localparam int GW  = FW + 3;
	localparam int DW  = FW + 4;
	localparam int PW  = 2 * FW + 6;
	localparam int IW  = FW + 4;
	localparam int RW  = GW + 8;
	localparam int SH  = COORD_FRAC_BITS - OUT_FRAC_BITS;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	localparam logic signed [RW-1:0] SAT_MAX = RW'(32767);
	localparam logic signed [RW-1:0] SAT_MIN = -RW'(32768);

	function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
		input logic signed [OW-1:0] x, input logic signed [OW-1:0] y,
		input logic signed [OW-1:0] z);
		logic signed [GW-1:0] a;
		logic signed [GW-1:0] b;
		a = (h < 4'd8) ? GW'(x) : GW'(y);
		if (h < 4'd4)
			b = GW'(y);
		else if (h == 4'd12 || h == 4'd14)
			b = GW'(x);
		else
			b = GW'(z);
		if (h[0])
			a = -a;
		if (h[1])
			b = -b;
		return a + b;
	endfunction

endpackage

>>> rtl/gnz_perm_ram.sv
module gnz_perm_ram (
	input  logic       clk,
	input  logic       we,
	input  logic [7:0] waddr,
	input  logic [7:0] wdata,
	input  logic       re,
	input  logic [7:0] raddr0,
	input  logic [7:0] raddr1,
	output logic [7:0] rdata0,
	output logic [7:0] rdata1
);
	logic [7:0] mem [256];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end
endmodule

>>> rtl/gnz_fade.sv
module gnz_fade (
	input  logic                      clk,
	input  logic                      en,
	input  logic [gnz_pkg::FW-1:0]    t,
	output logic [gnz_pkg::UW-1:0]    fade
);
	import gnz_pkg::*;

	logic [2*FW-1:0] tt_s1;
	logic [FW-1:0]   t_s1;
	logic [2*FW-1:0] t3p_s2;
	logic [IW-1:0]   inner_s2;
	logic [2*FW+3:0] fp_s3;

	logic [FW-1:0] t2;
	logic [FW-1:0] t3;
	logic [IW-1:0] inner;

	always_comb begin
		t2 = tt_s1[2*FW-1:FW];
		t3 = t3p_s2[2*FW-1:FW];
		inner = IW'(t2) * IW'(6) + (IW'(10) << FW) - IW'(t_s1) * IW'(15);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tt_s1    <= t * t;
			t_s1     <= t;
			t3p_s2   <= t2 * t_s1;
			inner_s2 <= inner;
			fp_s3    <= (2*FW+4)'(t3) * (2*FW+4)'(inner_s2);
		end
	end

	assign fade = fp_s3[2*FW:FW];
endmodule

>>> rtl/gnz_interp.sv
module gnz_interp (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [gnz_pkg::GW-1:0]   grads [8],
	input  logic [gnz_pkg::UW-1:0]          u,
	input  logic [gnz_pkg::UW-1:0]          v,
	input  logic [gnz_pkg::UW-1:0]          w,
	output logic signed [15:0]              noise
);
	import gnz_pkg::*;

	logic signed [GW-1:0] ax_s5 [4];
	logic signed [PW-1:0] px_s5 [4];
	logic [UW-1:0]        v_s5, w_s5, w_s6;
	logic signed [GW-1:0] ay_s6 [2];
	logic signed [PW-1:0] py_s6 [2];
	logic signed [GW-1:0] az_s7;
	logic signed [PW-1:0] pz_s7;
	logic signed [15:0]   noise_s8;

	logic signed [GW-1:0] lx [4];
	logic signed [GW-1:0] ly [2];
	logic signed [GW-1:0] r;
	logic signed [PW-1:0] sh;
	logic signed [RW-1:0] r_ext, r_cv;
	logic signed [15:0]   sat;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sh = px_s5[i] >>> FW;
			lx[i] = ax_s5[i] + sh[GW-1:0];
		end
		for (int j = 0; j < 2; j++) begin
			sh = py_s6[j] >>> FW;
			ly[j] = ay_s6[j] + sh[GW-1:0];
		end
		sh = pz_s7 >>> FW;
		r = az_s7 + sh[GW-1:0];
		r_ext = RW'(r);
	end

	generate
		if (SH > 0) begin : g_rnd
			always_comb r_cv = (r_ext + (RW'(1) <<< (SH - 1))) >>> SH;
		end else if (SH < 0) begin : g_up
			always_comb r_cv = r_ext <<< (-SH);
		end else begin : g_eq
			always_comb r_cv = r_ext;
		end
	endgenerate

	always_comb begin
		if (r_cv > SAT_MAX)
			sat = 16'sd32767;
		else if (r_cv < SAT_MIN)
			sat = -16'sd32768;
		else
			sat = r_cv[15:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				ax_s5[i] <= grads[2*i];
				px_s5[i] <= $signed({1'b0, u}) * $signed(DW'(grads[2*i+1]) - DW'(grads[2*i]));
			end
			v_s5 <= v;
			w_s5 <= w;
			for (int j = 0; j < 2; j++) begin
				ay_s6[j] <= lx[2*j];
				py_s6[j] <= $signed({1'b0, v_s5}) * $signed(DW'(lx[2*j+1]) - DW'(lx[2*j]));
			end
			w_s6 <= w_s5;
			az_s7 <= ly[0];
			pz_s7 <= $signed({1'b0, w_s6}) * $signed(DW'(ly[1]) - DW'(ly[0]));
			noise_s8 <= sat;
		end
	end

	assign noise = noise_s8;
endmodule

>>> rtl/gradient_noise_3d.sv
// channel | signals                                                  | transfer
// in      | in_valid, in_ready, cmd, entry_index, entry_value, coord_* | valid & ready
// out     | out_valid, out_ready, noise_value                        | valid & ready
//
// Evaluations: one per cycle while the output is not stalled; 8-stage pipeline
// (3 chained table reads, fade multiplies, 3 lerp multiplies, round/saturate).
// Loads write the table at transfer and produce nothing; a load waits while an
// evaluation is still in one of the two table read stages.
// arst_n clears valid bits only; the table is undefined until loaded.
// A stalled output holds the whole pipeline.
module gradient_noise_3d (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [7:0]         entry_index,
	input  logic [7:0]         entry_value,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] noise_value
);
	import gnz_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic adv, we;

	logic [7:0]    y_s1, z_s1, z_s2;
	logic [FW-1:0] fx_s1, fy_s1, fz_s1, fx_s2, fy_s2, fz_s2, fx_s3, fy_s3, fz_s3;
	logic signed [GW-1:0] g_s4 [8];
	logic [UW-1:0] u_s4, v4_s4, w_s4;
	logic [UW-1:0] fu, fv, fw;

	logic [7:0] ra0 [7];
	logic [7:0] ra1 [7];
	logic [7:0] rd0 [7];
	logic [7:0] rd1 [7];
	logic [7:0] a_h, b_h, aa, ab, ba, bb;
	logic signed [OW-1:0] x0, x1, y0, y1, z0, z1;
	logic signed [GW-1:0] g [8];

	assign adv = ~v_s8 | out_ready;
	assign in_ready = adv & ((cmd == CMD_EVAL) | ~(v_s1 | v_s2));
	assign we = in_valid & in_ready & (cmd == CMD_LOAD);

	always_comb begin
		a_h = rd0[0] + y_s1;
		b_h = rd1[0] + y_s1;
		aa  = rd0[1] + z_s2;
		ab  = rd1[1] + z_s2;
		ba  = rd0[2] + z_s2;
		bb  = rd1[2] + z_s2;
		ra0[0] = coord_x[FW+7:FW];
		ra1[0] = coord_x[FW+7:FW] + 8'd1;
		ra0[1] = a_h;
		ra1[1] = a_h + 8'd1;
		ra0[2] = b_h;
		ra1[2] = b_h + 8'd1;
		ra0[3] = aa;
		ra1[3] = aa + 8'd1;
		ra0[4] = ba;
		ra1[4] = ba + 8'd1;
		ra0[5] = ab;
		ra1[5] = ab + 8'd1;
		ra0[6] = bb;
		ra1[6] = bb + 8'd1;
		x0 = OW'({2'b00, fx_s3});
		x1 = OW'({2'b11, fx_s3});
		y0 = OW'({2'b00, fy_s3});
		y1 = OW'({2'b11, fy_s3});
		z0 = OW'({2'b00, fz_s3});
		z1 = OW'({2'b11, fz_s3});
		g[0] = grad(rd0[3][3:0], x0, y0, z0);
		g[1] = grad(rd0[4][3:0], x1, y0, z0);
		g[2] = grad(rd0[5][3:0], x0, y1, z0);
		g[3] = grad(rd0[6][3:0], x1, y1, z0);
		g[4] = grad(rd1[3][3:0], x0, y0, z1);
		g[5] = grad(rd1[4][3:0], x1, y0, z1);
		g[6] = grad(rd1[5][3:0], x0, y1, z1);
		g[7] = grad(rd1[6][3:0], x1, y1, z1);
	end

	// copy 0: X; 1,2: A, B; 3..6: AA, BA, AB, BB
	for (genvar k = 0; k < 7; k++) begin : g_ram
		gnz_perm_ram u_ram (
			.clk    (clk),
			.we     (we),
			.waddr  (entry_index),
			.wdata  (entry_value),
			.re     (adv),
			.raddr0 (ra0[k]),
			.raddr1 (ra1[k]),
			.rdata0 (rd0[k]),
			.rdata1 (rd1[k])
		);
	end

	gnz_fade u_fade_x (.clk(clk), .en(adv), .t(coord_x[FW-1:0]), .fade(fu));
	gnz_fade u_fade_y (.clk(clk), .en(adv), .t(coord_y[FW-1:0]), .fade(fv));
	gnz_fade u_fade_z (.clk(clk), .en(adv), .t(coord_z[FW-1:0]), .fade(fw));

	gnz_interp u_interp (
		.clk   (clk),
		.en    (adv),
		.grads (g_s4),
		.u     (u_s4),
		.v     (v4_s4),
		.w     (w_s4),
		.noise (noise_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid & (cmd == CMD_EVAL);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s1  <= coord_y[FW+7:FW];
			z_s1  <= coord_z[FW+7:FW];
			fx_s1 <= coord_x[FW-1:0];
			fy_s1 <= coord_y[FW-1:0];
			fz_s1 <= coord_z[FW-1:0];
			z_s2  <= z_s1;
			fx_s2 <= fx_s1;
			fy_s2 <= fy_s1;
			fz_s2 <= fz_s1;
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
			fz_s3 <= fz_s2;
			g_s4  <= g;
			u_s4  <= fu;
			v4_s4 <= fv;
			w_s4  <= fw;
		end
	end

	assign out_valid = v_s8;
endmodule

>>> tb/sv/gradient_noise_3d_tb.sv
module gradient_noise_3d_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gnz_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               cmd;
	logic [7:0]         entry_index;
	logic [7:0]         entry_value;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic signed [31:0] coord_z;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] noise_value;

	gradient_noise_3d dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .entry_index(entry_index), .entry_value(entry_value),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.out_valid(out_valid), .out_ready(out_ready), .noise_value(noise_value)
	);

	logic [7:0]         perm_copy [256];
	logic signed [15:0] noise_queue [$];
	int                 mismatches;
	int                 ready_gap;
	bit                 random_stall;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic longint floor_div(longint v);
		return v >>> COORD_FRAC_BITS;
	endfunction

	function automatic longint fade_val(longint t);
		longint one, t2, t3, inner;
		one = longint'(1) << COORD_FRAC_BITS;
		t2 = (t * t) >> COORD_FRAC_BITS;
		t3 = (t2 * t) >> COORD_FRAC_BITS;
		inner = 6 * t2 + 10 * one - 15 * t;
		return (t3 * inner) >> COORD_FRAC_BITS;
	endfunction

	function automatic longint corner_grad(logic [7:0] hash, longint x, longint y, longint z);
		logic [3:0] h;
		longint a, b;
		h = hash[3:0];
		a = (h < 8) ? x : y;
		b = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
		return ((h[0]) ? -a : a) + ((h[1]) ? -b : b);
	endfunction

	function automatic longint mix(longint w, longint a, longint b);
		return a + floor_div(w * (b - a));
	endfunction

	function automatic logic [7:0] pt(int i);
		return perm_copy[i & 255];
	endfunction

	function automatic logic signed [15:0] noise_at(logic signed [31:0] px,
		logic signed [31:0] py, logic signed [31:0] pz);
		longint one, fx, fy, fz, u, v, w, r;
		longint g0, g1, g2, g3, g4, g5, g6, g7;
		int xi, yi, zi, a, b, aa, ab, ba, bb, d;
		one = longint'(1) << COORD_FRAC_BITS;
		xi = int'(floor_div(longint'(px)) & 255);
		yi = int'(floor_div(longint'(py)) & 255);
		zi = int'(floor_div(longint'(pz)) & 255);
		fx = longint'(px) & (one - 1);
		fy = longint'(py) & (one - 1);
		fz = longint'(pz) & (one - 1);
		u = fade_val(fx);
		v = fade_val(fy);
		w = fade_val(fz);
		a = pt(xi) + yi;
		aa = pt(a) + zi;
		ab = pt(a + 1) + zi;
		b = pt(xi + 1) + yi;
		ba = pt(b) + zi;
		bb = pt(b + 1) + zi;
		g0 = corner_grad(pt(aa), fx, fy, fz);
		g1 = corner_grad(pt(ba), fx - one, fy, fz);
		g2 = corner_grad(pt(ab), fx, fy - one, fz);
		g3 = corner_grad(pt(bb), fx - one, fy - one, fz);
		g4 = corner_grad(pt(aa + 1), fx, fy, fz - one);
		g5 = corner_grad(pt(ba + 1), fx - one, fy, fz - one);
		g6 = corner_grad(pt(ab + 1), fx, fy - one, fz - one);
		g7 = corner_grad(pt(bb + 1), fx - one, fy - one, fz - one);
		r = mix(w, mix(v, mix(u, g0, g1), mix(u, g2, g3)),
			mix(v, mix(u, g4, g5), mix(u, g6, g7)));
		d = COORD_FRAC_BITS - OUT_FRAC_BITS;
		if (d > 0)
			r = (r + (longint'(1) << (d - 1))) >>> d;
		else if (d < 0)
			r = r <<< (-d);
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return 16'(r);
	endfunction

	task automatic send_item(logic c, logic [7:0] idx, logic [7:0] val,
		logic signed [31:0] px, logic signed [31:0] py, logic signed [31:0] pz);
		int gap;
		gap = random_stall ? int'($urandom_range(0, 19)) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		entry_index <= idx;
		entry_value <= val;
		coord_x <= px;
		coord_y <= py;
		coord_z <= pz;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (c == CMD_LOAD)
			perm_copy[idx] = val;
		else
			noise_queue.push_back(noise_at(px, py, pz));
		@(negedge clk);
	endtask

	task automatic load_entry(logic [7:0] idx, logic [7:0] val);
		send_item(CMD_LOAD, idx, val, $urandom, $urandom, $urandom);
	endtask

	task automatic eval_point(logic signed [31:0] px, logic signed [31:0] py,
		logic signed [31:0] pz);
		send_item(CMD_EVAL, 8'($urandom), 8'($urandom), px, py, pz);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (noise_queue.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic test_identity_table();
		for (int i = 0; i < 256; i++)
			load_entry(8'(i), 8'(i));
		eval_point(32'sh0, 32'sh0, 32'sh0);
		eval_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		eval_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
		eval_point(32'sh0000ffff, 32'sh0000ffff, 32'sh0000ffff);
		eval_point(32'sh00008000, 32'sh00008000, 32'sh00008000);
		eval_point(32'shffff0001, 32'sh00010000, 32'shffffffff);
		eval_point(32'sh00018000, 32'shfffe8000, 32'sh7fff0000);
	endtask

	task automatic test_random_table();
		int order [256];
		int j, tmp;
		for (int i = 0; i < 256; i++)
			order[i] = i;
		for (int i = 255; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < 256; i++)
			load_entry(8'(i), 8'(order[i]));
	endtask

	task automatic test_random_points(int n);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0: eval_point($urandom, $urandom, $urandom);
				1: eval_point(32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)),
					32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)),
					32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)));
				2: load_entry(8'($urandom), 8'($urandom));
				default: eval_point({$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom)},
					{16'($urandom), 16'($urandom_range(0, 1) ? 16'hffff : 16'h0)},
					$urandom);
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_LOAD;
		entry_index = '0;
		entry_value = '0;
		coord_x = '0;
		coord_y = '0;
		coord_z = '0;
		mismatches = 0;
		random_stall = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_identity_table();
		drain();
		random_stall = 1'b1;
		test_random_table();
		test_random_points(320);
		drain();
		random_stall = 1'b0;
		test_random_points(160);
		random_stall = 1'b1;
		test_random_points(300);
		drain();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			ready_gap = random_stall ? int'($urandom_range(0, 19)) : 0;
			if (ready_gap != 0) begin
				out_ready <= 1'b0;
				repeat (ready_gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!(arst_n && out_valid && out_ready));
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (noise_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: noise_value %0d", noise_value);
			end else begin
				if (noise_value !== noise_queue[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("noise_value mismatch: expected %0d actual %0d",
							noise_queue[0], noise_value);
				end
				void'(noise_queue.pop_front());
			end
		end
	end

	initial begin
		#2ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule
